// File: rtl/quaternion_normalizer_top_assert.svh
// assertion macros for the quaternion normalizer
`ifndef QUATERNION_NORMALIZER_TOP_ASSERT_SVH
`define QUATERNION_NORMALIZER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define QN_ASSERT_NOW(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define QN_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/qnorm_pkg.sv
// shared types, constants and the seed table of the quaternion normalizer
`default_nettype none

package qnorm_pkg;

	typedef logic signed [15:0] comp_t;
	typedef logic [30:0] sq_t;

	typedef struct packed {
		logic [31:0] m;
		logic [31:0] y;
		logic [5:0]  sh;
		logic        zero;
	} nstate_t;

	typedef struct packed {
		comp_t unit_a;
		comp_t unit_b;
		comp_t unit_c;
		comp_t unit_d;
		logic  zero_norm;
	} result_t;

	localparam logic [33:0] THREE_Q30 = 34'h0_C000_0000;
	localparam logic [30:0] UNIT_MAX  = 31'd16384;
	localparam logic [15:0] UNIT_ONE  = 16'd16384;
	localparam logic [5:0]  SH_BASE   = 6'd31;
	localparam logic [5:0]  SH_WIDE   = 6'd32;

	// 1/sqrt seed in q0.16, indexed by the top three bits of the mantissa
	function automatic logic [15:0] seed_q16(input logic [2:0] idx);
		logic [15:0] v;
		case (idx)
			3'd0:    v = 16'd65535;
			3'd1:    v = 16'd65535;
			3'd2:    v = 16'd59218;
			3'd3:    v = 16'd49797;
			3'd4:    v = 16'd43827;
			3'd5:    v = 16'd39602;
			3'd6:    v = 16'd36407;
			3'd7:    v = 16'd33880;
			default: v = 16'd65535;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/qnorm_lane.sv
// one component lane: square on entry, scale, round and saturate on exit
`default_nettype none

module qnorm_lane import qnorm_pkg::*; #(
	parameter int DLY = 1
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire comp_t       comp,
	output sq_t              sq,
	input  wire logic [31:0] y,
	input  wire logic [5:0]  sh,
	input  wire logic        zero,
	output comp_t            unit,
	output logic             zero_o
);

	logic signed [31:0] prod_sq;
	comp_t              comp_s1;
	sq_t                sq_s1;
	comp_t              dly_q [DLY];

	comp_t       comp_al;
	logic        neg_al;
	logic [15:0] mag_al;

	logic [47:0] scl_prod_s1;
	logic        scl_neg_s1;
	comp_t       scl_comp_s1;
	logic [5:0]  scl_sh_s1;
	logic        scl_zero_s1;

	logic [47:0] bias;
	logic [47:0] rsum;
	logic [47:0] shifted;

	logic [30:0] scl_rnd_s2;
	logic        scl_neg_s2;
	comp_t       scl_comp_s2;
	logic        scl_zero_s2;

	logic [15:0] mag_o;
	logic [15:0] res;

	assign prod_sq = comp * comp;

	always_ff @(posedge clk) begin
		if (en) begin
			comp_s1 <= comp;
			sq_s1   <= prod_sq[30:0];
			dly_q[0] <= comp_s1;
			for (int i = 1; i < DLY; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign sq = sq_s1;

	assign comp_al = dly_q[DLY-1];
	assign neg_al  = comp_al[15];
	assign mag_al  = neg_al ? (16'd0 - $unsigned(comp_al)) : $unsigned(comp_al);

	always_ff @(posedge clk) begin
		if (en) begin
			scl_prod_s1 <= mag_al * y;
			scl_neg_s1  <= neg_al;
			scl_comp_s1 <= comp_al;
			scl_sh_s1   <= sh;
			scl_zero_s1 <= zero;
		end
	end

	// round half away from zero on the magnitude
	assign bias    = 48'd1 << (scl_sh_s1 - 6'd1);
	assign rsum    = scl_prod_s1 + bias;
	assign shifted = rsum >> scl_sh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			scl_rnd_s2  <= shifted[30:0];
			scl_neg_s2  <= scl_neg_s1;
			scl_comp_s2 <= scl_comp_s1;
			scl_zero_s2 <= scl_zero_s1;
		end
	end

	always_comb begin
		mag_o = (scl_rnd_s2 > UNIT_MAX) ? UNIT_ONE : scl_rnd_s2[15:0];
		if (scl_zero_s2) begin
			res = $unsigned(scl_comp_s2);
		end else if (scl_neg_s2) begin
			res = 16'd0 - mag_o;
		end else begin
			res = mag_o;
		end
	end

	assign unit   = $signed(res);
	assign zero_o = scl_zero_s2;

endmodule

`default_nettype wire

// File: rtl/qnorm_newton.sv
// one newton step of the reciprocal square root, four pipeline stages
`default_nettype none

module qnorm_newton import qnorm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    en,
	input  wire nstate_t st_i,
	output nstate_t      st_o
);

	logic [63:0] p1_s1;
	nstate_t     st_s1;
	logic [63:0] p2_s2;
	nstate_t     st_s2;
	logic [33:0] t;
	logic [33:0] diff;
	logic [31:0] f_s3;
	nstate_t     st_s3;
	logic [63:0] p3_s4;
	nstate_t     st_s4;

	assign t    = p2_s2[63:30];
	assign diff = THREE_Q30 - t;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= st_i.y * st_i.y;
			st_s1 <= st_i;
			p2_s2 <= st_s1.m * p1_s1[61:30];
			st_s2 <= st_s1;
			f_s3  <= (t >= THREE_Q30) ? 32'd0 : diff[31:0];
			st_s3 <= st_s2;
			p3_s4 <= st_s3.y * f_s3;
			st_s4 <= st_s3;
		end
	end

	always_comb begin
		st_o   = st_s4;
		st_o.y = p3_s4[62:31];
	end

endmodule

`default_nettype wire

// File: rtl/qnorm_merge.sv
// merge of the lane squares: sum, even normalization and seed lookup
`default_nettype none

module qnorm_merge import qnorm_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire sq_t  sq [4],
	output nstate_t   st
);

	logic [31:0] pair_s2 [2];
	logic [32:0] sum_s3;

	logic        lz16;
	logic        lz8;
	logic [31:0] x1;
	logic [31:0] x2;
	logic [31:0] m_s4;
	logic [3:0]  k_s4;
	logic        wide_s4;
	logic        zero_s4;

	logic        lz4;
	logic        lz2;
	logic [31:0] x3;
	logic [31:0] x4;
	logic [3:0]  k5;
	logic [31:0] m_s5;
	logic [5:0]  sh_s5;
	logic        zero_s5;

	nstate_t     st_s6;

	// coarse leading-zero pairs
	assign lz16 = (sum_s3[31:16] == 16'd0);
	assign x1   = lz16 ? {sum_s3[15:0], 16'd0} : sum_s3[31:0];
	assign lz8  = (x1[31:24] == 8'd0);
	assign x2   = lz8 ? {x1[23:0], 8'd0} : x1;

	// fine leading-zero pairs
	assign lz4 = (m_s4[31:28] == 4'd0);
	assign x3  = lz4 ? {m_s4[27:0], 4'd0} : m_s4;
	assign lz2 = (x3[31:30] == 2'd0);
	assign x4  = lz2 ? {x3[29:0], 2'd0} : x3;
	assign k5  = {k_s4[3:2], lz4, lz2};

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2[0] <= {1'b0, sq[0]} + {1'b0, sq[1]};
			pair_s2[1] <= {1'b0, sq[2]} + {1'b0, sq[3]};
			sum_s3     <= {1'b0, pair_s2[0]} + {1'b0, pair_s2[1]};

			zero_s4 <= (sum_s3 == 33'd0);
			wide_s4 <= sum_s3[32];
			m_s4    <= sum_s3[32] ? {1'b0, sum_s3[32:2]} : x2;
			k_s4    <= sum_s3[32] ? 4'd0 : {lz16, lz8, 2'b00};

			m_s5    <= x4;
			sh_s5   <= wide_s4 ? SH_WIDE : (SH_BASE - {2'b00, k5});
			zero_s5 <= zero_s4;

			st_s6.m    <= m_s5;
			st_s6.y    <= {2'b00, seed_q16(m_s5[31:29]), 14'd0};
			st_s6.sh   <= sh_s5;
			st_s6.zero <= zero_s5;
		end
	end

	assign st = st_s6;

endmodule

`default_nettype wire

// File: rtl/quaternion_normalizer_top.sv
// quaternion normalizer top level: four lanes, merge, newton chain, output skid
//
// usage
//   one request on the input channel carries a quaternion comp_a..comp_d in
//   signed q3.12; the output channel returns unit_a..unit_d in signed q1.14
//   saturated to plus or minus one, and zero_norm for the zero quaternion,
//   which comes back unchanged
//   one request is taken every cycle while in_ready is high
//   each newton step is four stages (three multiplies and a subtract), the
//   lanes spend one stage on the square and two on scale and round
//   the whole pipeline moves on a single enable; a two-entry output skid
//   keeps taking requests while one result waits at the output, and
//   in_ready falls only when both entries are full
//   reset clears the stage valid bits and the skid, so no result is pending
//   and in_ready is high after reset
//   a stalled receiver holds unit_a..zero_norm stable with out_valid high
`default_nettype none

`include "quaternion_normalizer_top_assert.svh"

module quaternion_normalizer_top import qnorm_pkg::*; #(
	parameter int INV_SQRT_STEPS = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire comp_t comp_a,
	input  wire comp_t comp_b,
	input  wire comp_t comp_c,
	input  wire comp_t comp_d,
	output logic      out_valid,
	input  wire logic out_ready,
	output comp_t     unit_a,
	output comp_t     unit_b,
	output comp_t     unit_c,
	output comp_t     unit_d,
	output logic      zero_norm
);

	localparam int DLY   = 5 + 4 * INV_SQRT_STEPS;
	localparam int DEPTH = DLY + 3;

	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic             push;
	logic             pop;

	comp_t   comp_v [4];
	sq_t     sq_v   [4];
	comp_t   unit_v [4];
	logic    zero_v [4];
	nstate_t chain  [INV_SQRT_STEPS+1];

	result_t res_new;
	result_t out_q;
	result_t sp_q;
	logic    out_valid_q;
	logic    sp_valid_q;

	assign comp_v[0] = comp_a;
	assign comp_v[1] = comp_b;
	assign comp_v[2] = comp_c;
	assign comp_v[3] = comp_d;

	assign en       = !sp_valid_q;
	assign in_ready = en;
	assign push     = vld_q[DEPTH-1] && en;
	assign pop      = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		qnorm_lane #(
			.DLY(DLY)
		) u_lane (
			.clk   (clk),
			.en    (en),
			.comp  (comp_v[g]),
			.sq    (sq_v[g]),
			.y     (chain[INV_SQRT_STEPS].y),
			.sh    (chain[INV_SQRT_STEPS].sh),
			.zero  (chain[INV_SQRT_STEPS].zero),
			.unit  (unit_v[g]),
			.zero_o(zero_v[g])
		);
	end

	qnorm_merge u_merge (
		.clk(clk),
		.en (en),
		.sq (sq_v),
		.st (chain[0])
	);

	for (genvar s = 0; s < INV_SQRT_STEPS; s++) begin : g_newton
		qnorm_newton u_newton (
			.clk (clk),
			.en  (en),
			.st_i(chain[s]),
			.st_o(chain[s+1])
		);
	end

	always_comb begin
		res_new.unit_a    = unit_v[0];
		res_new.unit_b    = unit_v[1];
		res_new.unit_c    = unit_v[2];
		res_new.unit_d    = unit_v[3];
		res_new.zero_norm = zero_v[0] && zero_v[1] && zero_v[2] && zero_v[3];
	end

	// skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sp_valid_q  <= 1'b0;
		end else if (pop || !out_valid_q) begin
			if (sp_valid_q) begin
				out_valid_q <= 1'b1;
				sp_valid_q  <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			sp_valid_q <= 1'b1;
		end
	end

	// skid payload
	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (sp_valid_q) begin
				out_q <= sp_q;
				if (push) begin
					sp_q <= res_new;
				end
			end else begin
				out_q <= res_new;
			end
		end else if (push) begin
			sp_q <= res_new;
		end
	end

	assign out_valid = out_valid_q;
	assign unit_a    = out_q.unit_a;
	assign unit_b    = out_q.unit_b;
	assign unit_c    = out_q.unit_c;
	assign unit_d    = out_q.unit_d;
	assign zero_norm = out_q.zero_norm;

	`QN_ASSERT_NOW(a_spare_needs_head, clk, arst_n, sp_valid_q, out_valid_q, "skid spare without head")

	`QN_ASSERT_NEXT(a_stall_fills_spare, clk, arst_n, out_valid_q && !out_ready && !sp_valid_q && push, sp_valid_q && out_valid_q, "result lost under stall")

	`QN_ASSERT_NEXT(a_request_enters, clk, arst_n, in_valid && in_ready, vld_q[0], "accepted request not in pipeline")

	`QN_ASSERT_NOW(a_unit_range, clk, arst_n, out_valid && !zero_norm, (unit_a >= -16'sd16384) && (unit_a <= 16'sd16384) && (unit_b >= -16'sd16384) && (unit_b <= 16'sd16384) && (unit_c >= -16'sd16384) && (unit_c <= 16'sd16384) && (unit_d >= -16'sd16384) && (unit_d <= 16'sd16384), "unit component out of range")

endmodule

`default_nettype wire
